### design/centered_logo_pixel_blit_core_assert.svh
// Assertion macros for the centred logo blit core and its checker.
// No dependencies; included by the checker file.
`ifndef CENTERED_LOGO_PIXEL_BLIT_CORE_ASSERT_SVH
`define CENTERED_LOGO_PIXEL_BLIT_CORE_ASSERT_SVH

// Implication sampled on i_clk, ignored while reset is applied.
`define CLPB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication sampled on i_clk, ignored while reset is applied.
`define CLPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication sampled on i_clk that also holds through reset.
`define CLPB_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/clpb_pkg.sv
// Shared types, constants and the alpha premultiply function of the logo blit core.
// No dependencies.
`default_nettype none

package clpb_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_LINE_BYTES    = 3'd2,
        CFG_PIXEL_BYTES   = 3'd3,
        CFG_LOGO_WIDTH    = 3'd4,
        CFG_LOGO_HEIGHT   = 3'd5
    } t_cfg_index;

    localparam int unsigned CoordW  = 12;
    localparam int unsigned StrideW = 14;
    localparam int unsigned PixBW   = 3;
    localparam int unsigned ChanW   = 8;
    localparam int unsigned AddrW   = 26;
    localparam int unsigned DataW   = 32;
    localparam int unsigned CfgDataW = 14;

    localparam logic [CoordW-1:0]  SCREEN_WIDTH_RST  = 12'd800;
    localparam logic [CoordW-1:0]  SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [StrideW-1:0] LINE_BYTES_RST    = 14'd3200;
    localparam logic [PixBW-1:0]   PIXEL_BYTES_RST   = 3'd4;
    localparam logic [CoordW-1:0]  LOGO_WIDTH_RST    = 12'd256;
    localparam logic [CoordW-1:0]  LOGO_HEIGHT_RST   = 12'd128;

    localparam logic [PixBW-1:0] PIX_BYTES_WIDE   = 3'd4;
    localparam logic [PixBW-1:0] PIX_BYTES_NARROW = 3'd2;
    localparam logic [ChanW-1:0] ALPHA_THRESHOLD  = 8'd128;
    localparam logic [ChanW-1:0] RED_MASK_565     = 8'hF8;
    localparam logic [ChanW-1:0] GREEN_MASK_565   = 8'hFC;

    // c * a / 255 without a divider: (p + (p >> 8) + 1) >> 8 is exact for p <= 255 * 255
    function automatic logic [ChanW-1:0] premultiply(
        input logic [ChanW-1:0] c,
        input logic [ChanW-1:0] a
    );
        logic [2*ChanW-1:0] p;
        logic [2*ChanW:0]   s;
        p = c * a;
        s = {1'b0, p} + {9'd0, p[2*ChanW-1:ChanW]} + 17'd1;
        return s[2*ChanW-1:ChanW];
    endfunction

endpackage

`default_nettype wire

### design/centered_logo_pixel_blit_core.sv
// An input transfer reaches its write through the input register and then the result register.
// Throughput: one pixel per cycle while i_out_stall is low; the row-stride multiply
// and the three 8x8 premultiplies sit between the input register and the result register.
// Reset (synchronous, active low): counters to zero, registers to their defaults,
// both pipeline stages empty.
// Top level of the centred logo blit; uses clpb_pkg.
`default_nettype none

module centered_logo_pixel_blit_core
    import clpb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    // logo pixel stream
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ChanW-1:0]    i_blue,
    input  wire logic [ChanW-1:0]    i_green,
    input  wire logic [ChanW-1:0]    i_red,
    input  wire logic [ChanW-1:0]    i_alpha,
    // frame buffer writes
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [AddrW-1:0]         o_write_address,
    output logic [DataW-1:0]         o_write_data,
    output logic                     o_wide_write,
    output logic                     o_logo_done
);

    typedef logic signed [CoordW:0]   t_offset;
    typedef logic signed [CoordW+1:0] t_pos;

    logic [CoordW-1:0]  r_screen_width, r_screen_height, r_logo_width, r_logo_height;
    logic [StrideW-1:0] r_line_bytes;
    logic [PixBW-1:0]   r_pixel_bytes;

    logic [CoordW-1:0]  r_col, r_row;

    logic               r_s1_valid;
    logic [ChanW-1:0]   r_s1_blue, r_s1_green, r_s1_red, r_s1_alpha;
    t_pos               r_s1_dx, r_s1_dy;
    logic               r_s1_last;

    logic               r_out_valid;
    logic [AddrW-1:0]   r_write_address;
    logic [DataW-1:0]   r_write_data;
    logic               r_wide_write;
    logic               r_logo_done;

    logic        in_xfer, s2_load;
    t_offset     diff_x, diff_y, off_x, off_y;
    t_pos        n_dx, n_dy;
    logic [CoordW:0]   col_inc, row_inc;
    logic [CoordW-1:0] n_col, n_row;
    logic        n_last;

    logic        in_x, in_y, emit_wide, emit_narrow;
    logic [AddrW-1:0] row_addr, col_addr, n_write_address;
    logic [DataW-1:0] n_write_data;

    assign o_cfg_ready = 1'b1;

    // result register frees when empty or taken
    assign s2_load    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s2_load;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // signed centring offsets, truncated toward zero
    always_comb begin
        diff_x = $signed({1'b0, r_screen_width})  - $signed({1'b0, r_logo_width});
        diff_y = $signed({1'b0, r_screen_height}) - $signed({1'b0, r_logo_height});
        off_x  = (diff_x + $signed({{CoordW{1'b0}}, diff_x[CoordW]})) >>> 1;
        off_y  = (diff_y + $signed({{CoordW{1'b0}}, diff_y[CoordW]})) >>> 1;
        n_dx   = $signed({2'b00, r_col}) + $signed({off_x[CoordW], off_x});
        n_dy   = $signed({2'b00, r_row}) + $signed({off_y[CoordW], off_y});
    end

    // raster counters: wrap column at logo width, row at logo height
    always_comb begin
        col_inc = {1'b0, r_col} + 13'd1;
        row_inc = {1'b0, r_row} + 13'd1;
        n_last  = (col_inc == {1'b0, r_logo_width}) && (row_inc == {1'b0, r_logo_height});
        n_col   = col_inc[CoordW-1:0];
        n_row   = r_row;
        if (col_inc[CoordW-1:0] >= r_logo_width) begin
            n_col = '0;
            n_row = row_inc[CoordW-1:0];
            if (row_inc[CoordW-1:0] >= r_logo_height) begin
                n_row = '0;
            end
        end
    end

    // result stage: clip, address and pixel format
    always_comb begin
        in_x = !r_s1_dx[CoordW+1] && (r_s1_dx[CoordW:0] < {1'b0, r_screen_width});
        in_y = !r_s1_dy[CoordW+1] && (r_s1_dy[CoordW:0] < {1'b0, r_screen_height});
        emit_wide   = in_x && in_y && (r_pixel_bytes == PIX_BYTES_WIDE);
        emit_narrow = in_x && in_y && (r_pixel_bytes == PIX_BYTES_NARROW)
                      && (r_s1_alpha > ALPHA_THRESHOLD);
        row_addr = AddrW'(r_s1_dy[CoordW-1:0]) * AddrW'(r_line_bytes);
        col_addr = AddrW'(r_s1_dx[CoordW-1:0]) * AddrW'(r_pixel_bytes);
        n_write_address = row_addr + col_addr;
        if (r_pixel_bytes == PIX_BYTES_WIDE) begin
            n_write_data = {r_s1_alpha,
                            premultiply(r_s1_red, r_s1_alpha),
                            premultiply(r_s1_green, r_s1_alpha),
                            premultiply(r_s1_blue, r_s1_alpha)};
        end else begin
            // RGB565: red in 15..11, green in 10..5, blue in 4..0
            n_write_data = DataW'({r_s1_red & RED_MASK_565, 8'd0})
                         | DataW'({r_s1_green & GREEN_MASK_565, 3'd0})
                         | DataW'(r_s1_blue[ChanW-1:3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
            r_line_bytes    <= LINE_BYTES_RST;
            r_pixel_bytes   <= PIXEL_BYTES_RST;
            r_logo_width    <= LOGO_WIDTH_RST;
            r_logo_height   <= LOGO_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[CoordW-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[CoordW-1:0];
                CFG_LINE_BYTES:    r_line_bytes    <= i_cfg_data[StrideW-1:0];
                CFG_PIXEL_BYTES:   r_pixel_bytes   <= i_cfg_data[PixBW-1:0];
                CFG_LOGO_WIDTH:    r_logo_width    <= i_cfg_data[CoordW-1:0];
                CFG_LOGO_HEIGHT:   r_logo_height   <= i_cfg_data[CoordW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= r_s1_valid && (emit_wide || emit_narrow);
            end
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_blue  <= i_blue;
            r_s1_green <= i_green;
            r_s1_red   <= i_red;
            r_s1_alpha <= i_alpha;
            r_s1_dx    <= n_dx;
            r_s1_dy    <= n_dy;
            r_s1_last  <= n_last;
        end
        if (s2_load) begin
            r_write_address <= n_write_address;
            r_write_data    <= n_write_data;
            r_wide_write    <= (r_pixel_bytes == PIX_BYTES_WIDE);
            r_logo_done     <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_write_address;
    assign o_write_data    = r_write_data;
    assign o_wide_write    = r_wide_write;
    assign o_logo_done     = r_logo_done;

endmodule

`default_nettype wire

### design/clpb_checker.sv
// Port-level checker for the centred logo blit core, bound to the top level.
// Depends on centered_logo_pixel_blit_core_assert.svh.
`default_nettype none

`include "centered_logo_pixel_blit_core_assert.svh"

module clpb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [25:0] o_write_address,
    input wire logic [31:0] o_write_data,
    input wire logic        o_wide_write,
    input wire logic        o_logo_done
);

    // nothing pending straight out of reset
    `CLPB_ASSERT_ALWAYS(a_empty_after_reset, i_rst_n && !$past(i_rst_n), !o_out_valid, "result valid after reset")

    // a held result keeps its valid and its contents
    `CLPB_ASSERT_NEXT(a_hold_result, o_out_valid && i_out_stall, o_out_valid && $stable(o_write_address) && $stable(o_write_data) && $stable(o_wide_write) && $stable(o_logo_done), "stalled result changed")

    // two-byte writes leave the upper half clear
    `CLPB_ASSERT_IMPL(a_narrow_upper_zero, o_out_valid && !o_wide_write, o_write_data[31:16] == 16'd0, "RGB565 write has upper bits set")

    // premultiplied channels never exceed alpha
    `CLPB_ASSERT_IMPL(a_premult_bound, o_out_valid && o_wide_write, (o_write_data[7:0] <= o_write_data[31:24]) && (o_write_data[15:8] <= o_write_data[31:24]) && (o_write_data[23:16] <= o_write_data[31:24]), "premultiplied channel above alpha")

endmodule

bind centered_logo_pixel_blit_core clpb_checker u_clpb_checker (.*);

`default_nettype wire

### test/centered_logo_pixel_blit_core_tb.sv
// Self-checking testbench for centered_logo_pixel_blit_core: logo pixels in, frame buffer writes out.
// Tracks logo position and registers on its own and compares every write field by field.
// Depends on clpb_pkg and the core.
`default_nettype none

module centered_logo_pixel_blit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import clpb_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          BLOCK_LATENCY = 2;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned FULL_ALPHA    = 255;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [DataW-1:0] data;
        logic             wide;
        logic             done;
    } t_fb_write;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index     = '0;
    logic [CfgDataW-1:0] i_cfg_data      = '0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [ChanW-1:0]    i_blue          = '0;
    logic [ChanW-1:0]    i_green         = '0;
    logic [ChanW-1:0]    i_red           = '0;
    logic [ChanW-1:0]    i_alpha         = '0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic [AddrW-1:0]    o_write_address;
    logic [DataW-1:0]    o_write_data;
    logic                o_wide_write;
    logic                o_logo_done;

    // mirror of the register file and the logo position counters
    logic [CoordW-1:0]  cfg_screen_w    = SCREEN_WIDTH_RST;
    logic [CoordW-1:0]  cfg_screen_h    = SCREEN_HEIGHT_RST;
    logic [StrideW-1:0] cfg_line_bytes  = LINE_BYTES_RST;
    logic [PixBW-1:0]   cfg_pixel_bytes = PIXEL_BYTES_RST;
    logic [CoordW-1:0]  cfg_logo_w      = LOGO_WIDTH_RST;
    logic [CoordW-1:0]  cfg_logo_h      = LOGO_HEIGHT_RST;
    logic [CoordW-1:0]  logo_col        = '0;
    logic [CoordW-1:0]  logo_row        = '0;

    t_fb_write fb_writes_due[$];
    int        mismatches    = 0;
    int        cycles        = 0;
    int        in_idle_pct   = 0;
    int        out_stall_pct = 0;
    bit        hold_toggle   = 1'b0;
    bit        hold_seen     = 1'b0;
    int        hold_left     = 0;

    centered_logo_pixel_blit_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_alpha        (i_alpha),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_address(o_write_address),
        .o_write_data   (o_write_data),
        .o_wide_write   (o_wide_write),
        .o_logo_done    (o_logo_done)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("centered_logo_pixel_blit_core_tb: errors");
            $finish;
        end
    end

    function automatic logic [ChanW-1:0] scale_by_alpha(input logic [ChanW-1:0] c,
                                                        input logic [ChanW-1:0] a);
        int unsigned prod;
        prod = 32'(c) * 32'(a);
        return 8'(prod / FULL_ALPHA);
    endfunction

    // Work out the write (if any) for the pixel at the current logo position, then advance.
    function automatic void predict_fb_write(input logic [ChanW-1:0] b, input logic [ChanW-1:0] g,
                                             input logic [ChanW-1:0] r, input logic [ChanW-1:0] a);
        int        off_x;
        int        off_y;
        int        scr_x;
        int        scr_y;
        longint    byte_pos;
        t_fb_write w;
        bit        hit;
        off_x  = (int'(cfg_screen_w) - int'(cfg_logo_w)) / 2;
        off_y  = (int'(cfg_screen_h) - int'(cfg_logo_h)) / 2;
        scr_x  = off_x + int'(logo_col);
        scr_y  = off_y + int'(logo_row);
        w      = '0;
        w.done = (int'(logo_col) + 1 == int'(cfg_logo_w)) &&
                 (int'(logo_row) + 1 == int'(cfg_logo_h));
        hit    = 1'b0;
        if (scr_x >= 0 && scr_x < int'(cfg_screen_w) && scr_y >= 0 && scr_y < int'(cfg_screen_h)) begin
            byte_pos = longint'(scr_y) * longint'(cfg_line_bytes) +
                       longint'(scr_x) * longint'(cfg_pixel_bytes);
            w.addr = byte_pos[AddrW-1:0];
            if (cfg_pixel_bytes == PIX_BYTES_WIDE) begin
                w.data = {a, scale_by_alpha(r, a), scale_by_alpha(g, a), scale_by_alpha(b, a)};
                w.wide = 1'b1;
                hit    = 1'b1;
            end else if (cfg_pixel_bytes == PIX_BYTES_NARROW && a > ALPHA_THRESHOLD) begin
                // RGB565: red 5 bits, green 6 bits, blue 5 bits
                w.data = {16'd0, r[7:3], g[7:2], b[7:3]};
                w.wide = 1'b0;
                hit    = 1'b1;
            end
        end
        if (hit)
            fb_writes_due.push_back(w);
        logo_col = logo_col + 1'b1;
        if (logo_col >= cfg_logo_w) begin
            logo_col = '0;
            logo_row = logo_row + 1'b1;
            if (logo_row >= cfg_logo_h)
                logo_row = '0;
        end
    endfunction

    always @(posedge i_clk) begin : check_writes
        t_fb_write want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fb_writes_due.size() == 0) begin
                $error("unexpected write: write_address %0h write_data %0h",
                       o_write_address, o_write_data);
                mismatches++;
            end else begin
                want = fb_writes_due.pop_front();
                if (o_write_address !== want.addr) begin
                    $error("write_address expected %0h actual %0h", want.addr, o_write_address);
                    mismatches++;
                end
                if (o_write_data !== want.data) begin
                    $error("write_data expected %0h actual %0h", want.data, o_write_data);
                    mismatches++;
                end
                if (o_wide_write !== want.wide) begin
                    $error("wide_write expected %0b actual %0b", want.wide, o_wide_write);
                    mismatches++;
                end
                if (o_logo_done !== want.done) begin
                    $error("logo_done expected %0b actual %0b", want.done, o_logo_done);
                    mismatches++;
                end
            end
        end
    end

    // Output stall: random, or a long hold-off when the test asks for one.
    always @(negedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic send_pixel(input logic [ChanW-1:0] b, input logic [ChanW-1:0] g,
                              input logic [ChanW-1:0] r, input logic [ChanW-1:0] a);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_blue     = b;
        i_green    = g;
        i_red      = r;
        i_alpha    = a;
        do @(posedge i_clk); while (o_in_stall);
        predict_fb_write(b, g, r, a);
    endtask

    task automatic send_random_pixel();
        logic [ChanW-1:0] a;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 20)
            a = '0;
        else if (pick < 40)
            a = '1;
        else if (pick < 50)
            a = ALPHA_THRESHOLD + 8'($urandom_range(1));
        else
            a = 8'($urandom_range(255));
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), a);
    endtask

    // Drop valid, wait for every write to land, then let the pipeline empty.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (fb_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (BLOCK_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CfgDataW-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCREEN_WIDTH:  cfg_screen_w    = value[CoordW-1:0];
            CFG_SCREEN_HEIGHT: cfg_screen_h    = value[CoordW-1:0];
            CFG_LINE_BYTES:    cfg_line_bytes  = value[StrideW-1:0];
            CFG_PIXEL_BYTES:   cfg_pixel_bytes = value[PixBW-1:0];
            CFG_LOGO_WIDTH:    cfg_logo_w      = value[CoordW-1:0];
            CFG_LOGO_HEIGHT:   cfg_logo_h      = value[CoordW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_geometry(input int sw, input int sh, input int lb, input int pb,
                                  input int lw, input int lh);
        write_reg(CFG_SCREEN_WIDTH, CfgDataW'(sw));
        write_reg(CFG_SCREEN_HEIGHT, CfgDataW'(sh));
        write_reg(CFG_LINE_BYTES, CfgDataW'(lb));
        write_reg(CFG_PIXEL_BYTES, CfgDataW'(pb));
        write_reg(CFG_LOGO_WIDTH, CfgDataW'(lw));
        write_reg(CFG_LOGO_HEIGHT, CfgDataW'(lh));
    endtask

    task automatic test_default_registers();
        send_pixel('1, '1, '1, '0);
        send_pixel('1, '1, '1, '1);
        send_pixel(8'h5A, 8'hA5, 8'h3C, ALPHA_THRESHOLD);
        settle_block();
    endtask

    task automatic test_narrow_alpha_threshold();
        write_reg(CFG_PIXEL_BYTES, CfgDataW'(PIX_BYTES_NARROW));
        send_pixel('1, '1, '1, ALPHA_THRESHOLD);
        send_pixel('1, '1, '1, ALPHA_THRESHOLD + 1'b1);
        send_pixel(8'h07, 8'h03, 8'h07, '1);
        settle_block();
    endtask

    task automatic test_other_pixel_sizes();
        write_reg(CFG_PIXEL_BYTES, CfgDataW'(1));
        send_pixel('1, '1, '1, '1);
        settle_block();
        write_reg(CFG_PIXEL_BYTES, CfgDataW'(3));
        send_pixel('1, '1, '1, '1);
        settle_block();
    endtask

    // Shrink the logo under the running column counter: it wraps, then the rest of one frame and one full frame.
    task automatic test_logo_wrap_and_done();
        write_reg(CFG_PIXEL_BYTES, CfgDataW'(PIX_BYTES_WIDE));
        write_reg(CFG_LOGO_WIDTH, CfgDataW'(2));
        write_reg(CFG_LOGO_HEIGHT, CfgDataW'(2));
        repeat (7) send_random_pixel();
        settle_block();
    endtask

    // Logo wider and taller than the screen: edges clipped, last pixel dropped.
    task automatic test_off_screen_clip();
        write_geometry(2, 1, 16, int'(PIX_BYTES_WIDE), 4, 2);
        repeat (8) send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), '1);
        settle_block();
    endtask

    task automatic test_zero_logo_size();
        write_reg(CFG_LOGO_WIDTH, CfgDataW'(0));
        write_reg(CFG_LOGO_HEIGHT, CfgDataW'(3));
        repeat (3) send_random_pixel();
        settle_block();
    endtask

    task automatic test_register_extremes();
        write_geometry(4095, 4095, 16383, int'(PIX_BYTES_WIDE), 1, 1);
        repeat (2) send_random_pixel();
        settle_block();
        write_geometry(1, 1, 1, int'(PIX_BYTES_NARROW), 4095, 4095);
        repeat (2) send_pixel('1, '1, '1, '1);
        settle_block();
    endtask

    // Hold the output off for a long stretch while pixels keep coming, so the core backs up.
    task automatic test_output_hold_off();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_geometry(800, 480, 3200, int'(PIX_BYTES_WIDE), 16, 8);
        hold_toggle = ~hold_toggle;
        repeat (80) send_random_pixel();
        settle_block();
    endtask

    task automatic rand_config();
        int sw;
        int sh;
        int lw;
        int lh;
        int lb;
        int pb;
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            sw = $urandom_range(16, 1);
            sh = $urandom_range(16, 1);
        end else if (pick < 25) begin
            sw = 4095;
            sh = 4095;
        end else begin
            sw = $urandom_range(4095, 1);
            sh = $urandom_range(4095, 1);
        end
        lw   = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(4095, 1);
        lh   = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(4095, 1);
        pick = $urandom_range(99);
        lb   = (pick < 10) ? 16383 : (pick < 20) ? 1 : $urandom_range(16383, 1);
        pick = $urandom_range(99);
        pb   = (pick < 40) ? int'(PIX_BYTES_WIDE) : (pick < 80) ? int'(PIX_BYTES_NARROW) :
               (pick < 90) ? 1 : 3;
        write_geometry(sw, sh, lb, pb, lw, lh);
    endtask

    // Bursts of whole frames (or long partial ones) under fresh random geometry.
    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int items);
        int sent;
        int burst;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        sent          = 0;
        while (sent < items) begin
            rand_config();
            if (int'(cfg_logo_w) * int'(cfg_logo_h) <= 150)
                burst = int'(cfg_logo_w) * int'(cfg_logo_h) * $urandom_range(3, 1);
            else
                burst = $urandom_range(120, 20);
            if (burst > items - sent)
                burst = items - sent;
            repeat (burst) send_random_pixel();
            sent += burst;
            settle_block();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_registers();
        test_narrow_alpha_threshold();
        test_other_pixel_sizes();
        test_logo_wrap_and_done();
        test_off_screen_clip();
        test_zero_logo_size();
        test_register_extremes();
        test_output_hold_off();
        test_random_stream(0, 0, 450);
        test_random_stream(83, 0, 450);
        test_random_stream(0, 83, 450);
        test_random_stream(36, 36, 450);

        settle_block();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("centered_logo_pixel_blit_core_tb: clean");
        end else begin
            $display("centered_logo_pixel_blit_core_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
